[design/wrs_pkg.sv]
// Shared types and constants for the wavetable resampler with rate sweep.
// Used by wrs_ctrl, wrs_dp and wavetable_resampler_sweep; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wrs_pkg;

   // Default sizes, handed down as top-level parameter defaults
   localparam int TABLE_SIZE_DEFAULT  = 16384;
   localparam int SWEEP_TICKS_DEFAULT = 10000;

   // Item kinds carried on req_tuser
   localparam logic [1:0] OP_LOAD = 2'd0;
   localparam logic [1:0] OP_PLAY = 2'd1;
   localparam logic [1:0] OP_TICK = 2'd2;

   // Register indexes on the csr port
   localparam int          CSR_INDEX_W = 1;
   localparam logic [0:0]  CSR_VOLUME  = 1'b0;
   localparam logic [0:0]  CSR_ENABLE  = 1'b1;
   localparam int          CSR_DATA_W  = 7;

   // Field widths
   localparam int OPCODE_W  = 2;
   localparam int ADDRESS_W = 14;
   localparam int SAMPLE_W  = 8;
   localparam int FRAC_W    = 7;
   localparam int RATE_W    = 9;
   localparam int VOLUME_W  = 7;

   localparam logic [RATE_W-1:0]   RATE_LOW     = 9'd100;
   localparam logic [RATE_W-1:0]   RATE_HIGH    = 9'd300;
   localparam logic [RATE_W-1:0]   RATE_STEP    = 9'd20;
   localparam logic [VOLUME_W-1:0] VOLUME_RESET = 7'd70;

   // x / 100 == (x * 5243) >> 19, exact for x below 43690
   localparam int              RECIP_W     = 28;
   localparam logic [12:0]     RECIP_100   = 13'd5243;
   localparam int              RECIP_SHIFT = 19;

   // Controller to datapath step commands
   typedef struct packed {
      logic load_wr;
      logic tick;
      logic read_next;
      logic capture_s0;
      logic interp_mul;
      logic interp_div;
      logic scale_mul;
      logic scale_div;
      logic finish;
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic sound_enable;
   } dp_status_type;

endpackage

`default_nettype wire

[design/wrs_ctrl.sv]
// Sequencer for the wavetable resampler: decodes items, steps a play through
// the datapath and owns the result valid flag. Depends on wrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wrs_ctrl
   import wrs_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   input  wire logic [OPCODE_W-1:0] req_opcode,
   input  wire logic                rsp_tready,
   input  wire dp_status_type       status,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   output dp_cmd_type               cmd
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_FETCH  = 3'd1;
   localparam logic [2:0] ST_MUL    = 3'd2;
   localparam logic [2:0] ST_DIV    = 3'd3;
   localparam logic [2:0] ST_SCALE  = 3'd4;
   localparam logic [2:0] ST_NORM   = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_opcode)
                  OP_LOAD: cmd.load_wr = 1'b1;
                  OP_TICK: cmd.tick = 1'b1;
                  OP_PLAY: begin
                     if (status.sound_enable) begin
                        state_in = ST_FETCH;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            cmd.capture_s0 = 1'b1;
            cmd.read_next  = 1'b1;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.interp_mul = 1'b1;
            state_in       = ST_DIV;
         end
         ST_DIV: begin
            cmd.interp_div = 1'b1;
            state_in       = ST_SCALE;
         end
         ST_SCALE: begin
            cmd.scale_mul = 1'b1;
            state_in      = ST_NORM;
         end
         ST_NORM: begin
            cmd.scale_div = 1'b1;
            state_in      = ST_DONE;
         end
         ST_DONE: begin
            // hold until the output register can take the sample
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

[design/wrs_dp.sv]
// Datapath of the wavetable resampler: sample table, play position, rate
// sweep, control registers and the interpolation/volume pipeline. Uses wrs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module wrs_dp
   import wrs_pkg::*;
#(
   parameter int TABLE_SIZE  = TABLE_SIZE_DEFAULT,
   parameter int SWEEP_TICKS = SWEEP_TICKS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dp_cmd_type             cmd,
   input  wire logic [ADDRESS_W-1:0]   load_address,
   input  wire logic [SAMPLE_W-1:0]    load_sample,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data,
   output logic [SAMPLE_W-1:0]         audio_sample,
   output dp_status_type               status
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int XW = (AW > ADDRESS_W) ? AW : ADDRESS_W;
   localparam int PW = AW + 2;
   localparam int TW = (SWEEP_TICKS > 1) ? $clog2(SWEEP_TICKS) : 1;

   // sample table, contents undefined until loaded
   logic [SAMPLE_W-1:0] mem [TABLE_SIZE];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [AW-1:0]       rd_addr;
   logic [XW:0]         addr_x;
   logic                addr_ok;

   logic [AW-1:0]       pos_ff;
   logic [AW-1:0]       pos_in;
   logic [AW-1:0]       next_pos;
   logic [FRAC_W-1:0]   frac_ff;
   logic [FRAC_W-1:0]   frac_in;
   logic [RATE_W-1:0]   rate_ff;
   logic [RATE_W-1:0]   rate_in;
   logic                sweep_up_ff;
   logic                sweep_up_in;
   logic [TW-1:0]       tick_ff;
   logic [TW-1:0]       tick_in;
   logic [VOLUME_W-1:0] volume_ff;
   logic                enable_ff;

   logic [SAMPLE_W-1:0] s0_ff;
   logic                neg_ff;
   logic [14:0]         mag_ff;
   logic [SAMPLE_W-1:0] quot_ff;
   logic [14:0]         vm_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [SAMPLE_W-1:0] audio_ff;

   logic signed [8:0]   diff;
   logic signed [16:0]  prod;
   logic [16:0]         prod_abs;
   logic [RECIP_W-1:0]  quot_wide;
   logic [8:0]          vsum;
   logic [RECIP_W-1:0]  scale_wide;
   logic [8:0]          scaled;

   logic [RATE_W-1:0]   adv_sum;
   logic [1:0]          adv_step;
   logic [RATE_W-1:0]   adv_rem;
   logic [PW-1:0]       pos_w0;
   logic [PW-1:0]       pos_w1;
   logic [PW-1:0]       pos_w2;

   // table port: one write from load items, one registered read
   assign addr_x   = (XW + 1)'(load_address);
   assign addr_ok  = addr_x < (XW + 1)'(TABLE_SIZE);
   assign next_pos = (pos_ff == AW'(TABLE_SIZE - 1)) ? '0 : pos_ff + 1'b1;
   assign rd_addr  = cmd.read_next ? next_pos : pos_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_wr && addr_ok) begin
         mem[addr_x[AW-1:0]] <= load_sample;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // interpolation: s0 + trunc((s1 - s0) * frac / 100)
   assign diff     = $signed({1'b0, rd_data_ff}) - $signed({1'b0, s0_ff});
   assign prod     = 17'(diff) * 17'($signed({1'b0, frac_ff}));
   assign prod_abs = prod[16] ? 17'(-prod) : 17'(prod);
   assign quot_wide = RECIP_W'(mag_ff) * RECIP_W'(RECIP_100);
   assign vsum = neg_ff ? ({1'b0, s0_ff} - {1'b0, quot_ff})
                        : ({1'b0, s0_ff} + {1'b0, quot_ff});
   assign scale_wide = RECIP_W'(vm_ff) * RECIP_W'(RECIP_100);
   assign scaled     = scale_wide[RECIP_SHIFT +: 9];

   always_ff @(posedge clock) begin
      if (cmd.capture_s0) begin
         s0_ff <= rd_data_ff;
      end
      if (cmd.interp_mul) begin
         neg_ff <= prod[16];
         mag_ff <= prod_abs[14:0];
      end
      if (cmd.interp_div) begin
         quot_ff <= quot_wide[RECIP_SHIFT +: SAMPLE_W];
      end
      if (cmd.scale_mul) begin
         vm_ff <= 15'(vsum[7:0]) * 15'(volume_ff);
      end
      if (cmd.scale_div) begin
         // saturate scaled results above 255
         sample_ff <= scaled[8] ? 8'hFF : scaled[7:0];
      end
      if (cmd.finish) begin
         audio_ff <= sample_ff;
      end
   end

   assign audio_sample = audio_ff;

   // advance position by rate hundredths
   always_comb begin
      adv_sum = RATE_W'(frac_ff) + rate_ff;
      if (adv_sum >= 9'd300) begin
         adv_step = 2'd3;
         adv_rem  = adv_sum - 9'd300;
      end else if (adv_sum >= 9'd200) begin
         adv_step = 2'd2;
         adv_rem  = adv_sum - 9'd200;
      end else if (adv_sum >= 9'd100) begin
         adv_step = 2'd1;
         adv_rem  = adv_sum - 9'd100;
      end else begin
         adv_step = 2'd0;
         adv_rem  = adv_sum;
      end
      pos_w0 = PW'(pos_ff) + PW'(adv_step);
      // wrap twice at most, needed for very small tables
      pos_w1 = (pos_w0 >= PW'(TABLE_SIZE)) ? pos_w0 - PW'(TABLE_SIZE) : pos_w0;
      pos_w2 = (pos_w1 >= PW'(TABLE_SIZE)) ? pos_w1 - PW'(TABLE_SIZE) : pos_w1;
      pos_in  = pos_ff;
      frac_in = frac_ff;
      if (cmd.finish) begin
         pos_in  = pos_w2[AW-1:0];
         frac_in = adv_rem[FRAC_W-1:0];
      end
   end

   // rate sweep on tick
   always_comb begin
      tick_in     = tick_ff;
      rate_in     = rate_ff;
      sweep_up_in = sweep_up_ff;
      if (cmd.tick) begin
         if (tick_ff == TW'(SWEEP_TICKS - 1)) begin
            tick_in = '0;
            if (rate_ff >= RATE_HIGH) begin
               sweep_up_in = 1'b0;
            end else if (rate_ff <= RATE_LOW) begin
               sweep_up_in = 1'b1;
            end
            rate_in = sweep_up_in ? rate_ff + RATE_STEP : rate_ff - RATE_STEP;
         end else begin
            tick_in = tick_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         frac_ff     <= '0;
         rate_ff     <= RATE_LOW;
         sweep_up_ff <= 1'b1;
         tick_ff     <= '0;
         volume_ff   <= VOLUME_RESET;
         enable_ff   <= 1'b1;
      end else begin
         pos_ff      <= pos_in;
         frac_ff     <= frac_in;
         rate_ff     <= rate_in;
         sweep_up_ff <= sweep_up_in;
         tick_ff     <= tick_in;
         if (csr_write) begin
            case (csr_index)
               CSR_VOLUME: volume_ff <= csr_data;
               CSR_ENABLE: enable_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   assign status.sound_enable = enable_ff;

endmodule

`default_nettype wire

[design/wavetable_resampler_sweep.sv]
// Top level of the wavetable resampler with rate sweep: joins wrs_ctrl and
// wrs_dp. Depends on wrs_pkg, wrs_ctrl and wrs_dp.
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_tvalid/tready    tdata address+sample, tuser kind
//   rsp_      out        rsp_tvalid/tready    tdata audio sample
//   csr_      in         csr_valid/ready      csr_index, csr_data
//
// Load, tick and unused items are done in their transfer cycle; a play item
// with sound on runs in steps: two reads through the sample table's read port,
// then two multiply and reciprocal-divide steps, then the output register load.
// A play with sound off is done in its transfer cycle and gives no result.
// A finished sample waits in the output register while the next item enters;
// a second play stalls in its last step until that register frees up.
// Synchronous reset; the sample table is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module wavetable_resampler_sweep
   import wrs_pkg::*;
#(
   parameter int TABLE_SIZE  = TABLE_SIZE_DEFAULT,
   parameter int SWEEP_TICKS = SWEEP_TICKS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [23:0]            req_tdata,   // load_address, load_sample
   input  wire logic [OPCODE_W-1:0]    req_tuser,   // opcode
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [SAMPLE_W-1:0]         rsp_tdata,   // audio_sample
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   wrs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_opcode (req_tuser),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .cmd        (cmd)
   );

   wrs_dp #(
      .TABLE_SIZE  (TABLE_SIZE),
      .SWEEP_TICKS (SWEEP_TICKS)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .load_address (req_tdata[ADDRESS_W-1:0]),
      .load_sample  (req_tdata[ADDRESS_W +: SAMPLE_W]),
      .csr_write    (csr_valid && csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .audio_sample (rsp_tdata),
      .status       (status)
   );

   // an enabled play closes the input until its sample is done
   a_play_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == OP_PLAY && status.sound_enable)
      |=> !req_tready)
      else $error("play transfer did not close the input");

   // other items finish in the transfer cycle
   a_other_single: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser != OP_PLAY) |=> req_tready)
      else $error("non-play item held the input");

   // a new result only comes out of a play in progress
   a_rsp_from_play: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without a play in progress");

endmodule

`default_nettype wire

[bench/wavetable_resampler_sweep_tb.sv]
// Self-checking bench for wavetable_resampler_sweep: fills the start of the sample
// table, walks a directed table, then random traffic with stalls, all scored live.
// Depends on wrs_pkg and the wavetable_resampler_sweep RTL.
`timescale 1ns / 1ps

module wavetable_resampler_sweep_tb;
   import wrs_pkg::*;

   localparam int TABLE_DEPTH    = TABLE_SIZE_DEFAULT;
   localparam int SWEEP_PERIOD   = SWEEP_TICKS_DEFAULT;
   localparam int FILL_DEPTH     = 256;
   localparam int SETTLE_CYCLES  = 12;
   localparam int LONG_HOLD      = 300;
   localparam int DRAIN_LIMIT    = 5000;
   localparam int PHASE_ITEMS    = 210;
   localparam int MIX_PHASES     = 5;
   localparam int REPORT_LIMIT   = 10;

   localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [23:0]            req_tdata;   // load_address, load_sample, zero pad
   logic [OPCODE_W-1:0]    req_tuser;   // opcode
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [SAMPLE_W-1:0]    rsp_tdata;   // audio_sample
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   wavetable_resampler_sweep i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Directed rows: either a register write or one input item
   typedef struct packed {
      logic                   is_csr;
      logic [CSR_INDEX_W-1:0] csr_idx;
      logic [OPCODE_W-1:0]    op;
      logic [ADDRESS_W-1:0]   addr;
      logic [SAMPLE_W-1:0]    din;
      logic                   typed;
      logic [SAMPLE_W-1:0]    want;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 23;
   localparam directed_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{1'b0, CSR_VOLUME, OP_LOAD,   14'd0,      8'd200,  1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_LOAD,   14'd1,      8'd100,  1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_LOAD,   14'd2,      8'd255,  1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_LOAD,   14'd3,      8'd0,    1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_LOAD,   14'h3FFF,   8'd255,  1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_LOAD,   14'h2AAA,   8'h55,   1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_LOAD,   14'h1555,   8'hAA,   1'b0, 8'd0},
      // reset volume of 70 percent on entry 0
      '{1'b0, CSR_VOLUME, OP_PLAY,   14'd0,      8'd0,    1'b1, 8'd140},
      '{1'b1, CSR_VOLUME, OP_LOAD,   14'd0,      8'd100,  1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_PLAY,   14'd0,      8'd0,    1'b1, 8'd100},
      '{1'b1, CSR_VOLUME, OP_LOAD,   14'd0,      8'd127,  1'b0, 8'd0},
      // full-scale sample above 100 percent saturates
      '{1'b0, CSR_VOLUME, OP_PLAY,   14'd0,      8'd0,    1'b1, 8'd255},
      '{1'b1, CSR_VOLUME, OP_LOAD,   14'd0,      8'd0,    1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_PLAY,   14'd0,      8'd0,    1'b1, 8'd0},
      '{1'b1, CSR_ENABLE, OP_LOAD,   14'd0,      8'd0,    1'b0, 8'd0},
      // muted play: no sample, position holds
      '{1'b0, CSR_VOLUME, OP_PLAY,   14'h3FFF,   8'hFF,   1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_UNUSED, 14'h3FFF,   8'hFF,   1'b0, 8'd0},
      '{1'b1, CSR_ENABLE, OP_LOAD,   14'd0,      8'd1,    1'b0, 8'd0},
      '{1'b1, CSR_VOLUME, OP_LOAD,   14'd0,      8'd100,  1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_PLAY,   14'd0,      8'd0,    1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_TICK,   14'h3FFF,   8'hFF,   1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_PLAY,   14'd0,      8'd0,    1'b0, 8'd0},
      '{1'b0, CSR_VOLUME, OP_LOAD,   14'd5,      8'd0,    1'b0, 8'd0}
   };

   localparam logic [CSR_DATA_W-1:0] PHASE_VOLUME [MIX_PHASES] = '{7'd50, 7'd100, 7'd127,
                                                                  7'd1, 7'd0};
   localparam logic PHASE_ENABLE [MIX_PHASES] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1};

   // Predicted block state
   logic [SAMPLE_W-1:0]  wave_copy [0:TABLE_DEPTH-1];
   bit                   wave_known [0:TABLE_DEPTH-1];
   logic [ADDRESS_W-1:0] play_pos;
   logic [FRAC_W-1:0]    play_frac;
   logic [RATE_W-1:0]    play_rate;
   bit                   sweeping_up;
   int                   tick_total;
   logic [VOLUME_W-1:0]  volume_setting;
   bit                   enable_setting;

   logic [SAMPLE_W-1:0]  pending_audio [$];

   bit send_gaps;
   bit rsp_stalls;
   bit hold_rsp;

   int items_accepted;
   int samples_checked;
   int fault_count;
   int sweeps_done;
   int wraps_seen;
   int rate_floor;
   int rate_peak;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Advance the predicted state by one accepted item
   task automatic resample_step(input logic [OPCODE_W-1:0] op,
                                input logic [ADDRESS_W-1:0] addr,
                                input logic [SAMPLE_W-1:0] din,
                                output bit produced,
                                output logic [SAMPLE_W-1:0] audio);
      int s0;
      int s1;
      int level;
      int scaled;
      int total;
      int next_pos;
      produced = 1'b0;
      audio    = '0;
      case (op)
         OP_LOAD: begin
            if (int'(addr) < TABLE_DEPTH) begin
               wave_copy[addr]  = din;
               wave_known[addr] = 1'b1;
            end
         end
         OP_PLAY: begin
            if (enable_setting) begin
               s0     = int'(wave_copy[play_pos]);
               s1     = int'(wave_copy[(int'(play_pos) + 1) % TABLE_DEPTH]);
               // signed division truncates toward zero
               level  = s0 + ((s1 - s0) * int'(play_frac)) / 100;
               scaled = (level * int'(volume_setting)) / 100;
               if (scaled > 255)
                  scaled = 255;
               produced = 1'b1;
               audio    = SAMPLE_W'(scaled);
               total    = int'(play_frac) + int'(play_rate);
               next_pos = (int'(play_pos) + total / 100) % TABLE_DEPTH;
               if (next_pos < int'(play_pos))
                  wraps_seen++;
               play_pos  = ADDRESS_W'(next_pos);
               play_frac = FRAC_W'(total % 100);
            end
         end
         OP_TICK: begin
            tick_total++;
            if (tick_total >= SWEEP_PERIOD) begin
               tick_total = 0;
               if (play_rate >= RATE_HIGH)
                  sweeping_up = 1'b0;
               else if (play_rate <= RATE_LOW)
                  sweeping_up = 1'b1;
               play_rate = sweeping_up ? play_rate + RATE_STEP : play_rate - RATE_STEP;
               sweeps_done++;
               if (int'(play_rate) < rate_floor)
                  rate_floor = int'(play_rate);
               if (int'(play_rate) > rate_peak)
                  rate_peak = int'(play_rate);
            end
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input logic [OPCODE_W-1:0] op,
                            input logic [ADDRESS_W-1:0] addr,
                            input logic [SAMPLE_W-1:0] din,
                            input bit typed = 1'b0,
                            input logic [SAMPLE_W-1:0] want = '0);
      int unsigned gap;
      bit produced;
      logic [SAMPLE_W-1:0] audio;
      gap = send_gaps ? pick_gap() : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, din, addr};
      do @(posedge clock); while (!req_tready);
      items_accepted++;
      resample_step(op, addr, din, produced, audio);
      if (produced)
         pending_audio.push_back(typed ? want : audio);
   endtask

   // Load the two entries a play reads if they were never written, then play
   task automatic send_play();
      logic [ADDRESS_W-1:0] nxt;
      nxt = ADDRESS_W'((int'(play_pos) + 1) % TABLE_DEPTH);
      if (!wave_known[play_pos])
         send_item(OP_LOAD, play_pos, SAMPLE_W'($urandom));
      if (!wave_known[nxt])
         send_item(OP_LOAD, nxt, SAMPLE_W'($urandom));
      send_item(OP_PLAY, ADDRESS_W'($urandom), SAMPLE_W'($urandom));
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_VOLUME)
         volume_setting = val;
      else
         enable_setting = val[0];
      @(posedge clock);
   endtask

   // Stop offering, let every sample out, then allow for a muted play in flight
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_audio.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(100_000_000);
      $display("Mismatches found");
      $finish;
   end

   // Result side: random stalls, plus one long hold-off on request
   initial begin
      int unsigned stall;
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_rsp = 1'b0;
            rsp_tready <= 1'b1;
         end else if (rsp_stalls && $urandom_range(0, 3) == 0) begin
            stall = pick_gap() + 1;
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      logic [SAMPLE_W-1:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         samples_checked++;
         if (pending_audio.size() == 0) begin
            fault_count++;
            if (fault_count <= REPORT_LIMIT)
               $display("Unexpected audio sample %0d at %0t", rsp_tdata, $realtime);
         end else begin
            want = pending_audio.pop_front();
            if (rsp_tdata !== want) begin
               fault_count++;
               if (fault_count <= REPORT_LIMIT)
                  $display("Audio sample mismatch at %0t: expected %0d, got %0d",
                           $realtime, want, rsp_tdata);
            end
         end
      end
   end

   initial begin
      int row;
      int phase;
      int n;
      int pick;
      int waited;
      logic [ADDRESS_W-1:0] addr;
      logic [SAMPLE_W-1:0]  din;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_LOAD;
      csr_valid  = 1'b0;
      csr_index  = CSR_VOLUME;
      csr_data   = '0;
      send_gaps  = 1'b0;
      rsp_stalls = 1'b1;
      hold_rsp   = 1'b0;

      play_pos       = '0;
      play_frac      = '0;
      play_rate      = RATE_LOW;
      sweeping_up    = 1'b1;
      tick_total     = 0;
      volume_setting = VOLUME_RESET;
      enable_setting = 1'b1;
      rate_floor     = int'(RATE_LOW);
      rate_peak      = int'(RATE_LOW);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Fill the start of the table; plays further on load their entries first
      for (n = 0; n < FILL_DEPTH; n++) begin
         pick = $urandom_range(0, 7);
         din  = (pick == 0) ? 8'd0 : (pick == 1) ? 8'd255 : SAMPLE_W'($urandom);
         send_item(OP_LOAD, ADDRESS_W'(n), din);
      end

      send_gaps = 1'b1;
      for (row = 0; row < DIRECTED_ROWS; row++) begin
         if (DIRECTED[row].is_csr) begin
            settle();
            write_csr(DIRECTED[row].csr_idx, DIRECTED[row].din[CSR_DATA_W-1:0]);
         end else begin
            send_item(DIRECTED[row].op, DIRECTED[row].addr, DIRECTED[row].din,
                      DIRECTED[row].typed, DIRECTED[row].want);
         end
      end

      for (phase = 0; phase < MIX_PHASES; phase++) begin
         settle();
         write_csr(CSR_VOLUME, PHASE_VOLUME[phase]);
         write_csr(CSR_ENABLE, CSR_DATA_W'(PHASE_ENABLE[phase]));
         // one phase runs without random gaps or random stalls on either side
         send_gaps  = (phase != 1);
         rsp_stalls = (phase != 1);
         if (phase == 1) begin
            // hold the result side off while plays keep coming to back up the input
            hold_rsp = 1'b1;
            repeat (8) send_play();
         end
         for (n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30) begin
               addr = ($urandom_range(0, 1) != 0) ? ADDRESS_W'($urandom)
                                                  : play_pos + ADDRESS_W'($urandom_range(0, 3));
               send_item(OP_LOAD, addr, SAMPLE_W'($urandom));
            end else if (pick < 75) begin
               send_play();
            end else if (pick < 94) begin
               send_item(OP_TICK, ADDRESS_W'($urandom), SAMPLE_W'($urandom));
            end else begin
               send_item(OP_UNUSED, ADDRESS_W'($urandom), SAMPLE_W'($urandom));
            end
         end
      end
      rsp_stalls = 1'b1;

      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_audio.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_audio.size() != 0) begin
         fault_count += pending_audio.size();
         $display("%0d expected audio samples never arrived", pending_audio.size());
      end

      $display("Covered %0d input transfers, %0d audio samples checked, %0d rate sweeps",
               items_accepted, samples_checked, sweeps_done);
      $display("Rate spanned %0d..%0d hundredths, play position wrapped %0d time(s)",
               rate_floor, rate_peak, wraps_seen);
      if (fault_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

[sim.f]
design/wrs_pkg.sv
design/wrs_ctrl.sv
design/wrs_dp.sv
design/wavetable_resampler_sweep.sv
bench/wavetable_resampler_sweep_tb.sv
